### design/str_pkg.sv
// Shared types, constants and helpers of the supersampled triangle rasteriser.
package str_pkg;

  localparam int VW    = 13;  // vertex coordinate, 1/16 pixel
  localparam int CW    = 32;  // RGBA8 word
  localparam int RW    = 4;   // effective sample rate
  localparam int BW    = 10;  // bounding box in whole pixels
  localparam int SW    = 13;  // sample coordinate, signed
  localparam int XW    = 20;  // scaled vertex coordinate
  localparam int OPW   = 24;  // shared multiplier operand
  localparam int PW    = 48;  // shared multiplier product
  localparam int EW    = 48;  // edge function accumulator
  localparam int CNTW  = 17;  // covered sample count
  localparam int NSTEP = 19;  // setup multiplications per draw

  localparam logic REG_RATE  = 1'b0;
  localparam logic CMD_DRAW  = 1'b0;
  localparam logic CMD_READ  = 1'b1;
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_CR1, OP_CR2,
    OP_SX0, OP_SY0, OP_SX1, OP_SY1, OP_SX2, OP_SY2,
    OP_LOX, OP_HIX, OP_LOY, OP_HIY, OP_RB,
    OP_E0A, OP_E0B, OP_E1A, OP_E1B, OP_E2A, OP_E2B,
    OP_RDB
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_INIT, ST_SCAN, ST_DRAIN, ST_DONE,
    ST_RD_MUL, ST_RD_STORE, ST_RD_REQ, ST_RD_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_en;
    op_t  op;
    logic scan_init;
    logic scan_en;
    logic rd_req;
    logic rd_capture;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic bbox_empty;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  function automatic op_t setup_op(input logic [4:0] step);
    op_t r;
    case (step)
      5'd0:    r = OP_CR1;
      5'd1:    r = OP_CR2;
      5'd2:    r = OP_SX0;
      5'd3:    r = OP_SY0;
      5'd4:    r = OP_SX1;
      5'd5:    r = OP_SY1;
      5'd6:    r = OP_SX2;
      5'd7:    r = OP_SY2;
      5'd8:    r = OP_LOX;
      5'd9:    r = OP_HIX;
      5'd10:   r = OP_LOY;
      5'd11:   r = OP_HIY;
      5'd12:   r = OP_RB;
      5'd13:   r = OP_E0A;
      5'd14:   r = OP_E0B;
      5'd15:   r = OP_E1A;
      5'd16:   r = OP_E1B;
      5'd17:   r = OP_E2A;
      5'd18:   r = OP_E2B;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic signed [VW-1:0] min3(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b,
                                                input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VW-1:0] max3(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b,
                                                input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

### design/str_ram.sv
// Generic single-write, single-read RAM with registered read data.
module str_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/str_ctrl.sv
// Controller state machine: clear pass, setup sequence, scan, drain, reads, result hand-off.
module str_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_ready,
  input  str_pkg::dp_status_t status,
  output str_pkg::ctrl_cmd_t  cmd
);
  import str_pkg::*;

  state_t     state, state_next;
  logic [4:0] step, step_next;
  logic       phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      step  <= '0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    phase_next = phase;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = OP_NONE;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          phase_next = 1'b0;
          state_next = (in_cmd == CMD_READ) ? ST_RD_MUL : ST_SETUP;
        end
      end
      ST_SETUP: begin
        // phase 0 issues a multiplication; phase 1 waits while its product lands
        if (!phase) begin
          cmd.op     = setup_op(step);
          phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          if (step == 5'(NSTEP - 1)) state_next = ST_INIT;
          else step_next = step + 5'd1;
        end
      end
      ST_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = status.bbox_empty ? ST_DRAIN : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_RD_MUL: begin
        cmd.op     = OP_RDB;
        state_next = ST_RD_STORE;
      end
      ST_RD_STORE: state_next = ST_RD_REQ;
      ST_RD_REQ: begin
        cmd.rd_req = 1'b1;
        state_next = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = ST_DONE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### design/str_dp.sv
// Datapath: shared multiplier, edge stepping, sample store, blend pipeline, result register.
module str_dp #(
  parameter int SCREEN_W = 64,
  parameter int SCREEN_H = 64,
  parameter int MAX_RATE = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  str_pkg::ctrl_cmd_t           cmd,
  output str_pkg::dp_status_t          status,
  input  logic [2:0]                   rate_cfg,
  input  logic                         in_cmd,
  input  logic signed [str_pkg::VW-1:0] vx0,
  input  logic signed [str_pkg::VW-1:0] vy0,
  input  logic signed [str_pkg::VW-1:0] vx1,
  input  logic signed [str_pkg::VW-1:0] vy1,
  input  logic signed [str_pkg::VW-1:0] vx2,
  input  logic signed [str_pkg::VW-1:0] vy2,
  input  logic [str_pkg::CW-1:0]       color_rgba,
  input  logic [7:0]                   read_sx,
  input  logic [7:0]                   read_sy,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         result_kind,
  output logic [str_pkg::CW-1:0]       sample_rgba,
  output logic [str_pkg::CNTW-1:0]     covered_count
);
  import str_pkg::*;

  localparam int DEPTH = SCREEN_W * MAX_RATE * SCREEN_H * MAX_RATE;
  localparam int AW    = $clog2(DEPTH);

  // effective rate and store geometry
  logic [RW-1:0]        rate_eff;
  logic signed [SW-1:0] sw_s, sh_s;

  always_comb begin
    if (rate_cfg == 3'd0) rate_eff = RW'(1);
    else if ({1'b0, rate_cfg} > RW'(MAX_RATE)) rate_eff = RW'(MAX_RATE);
    else rate_eff = RW'(rate_cfg);
  end
  assign sw_s = SW'(SCREEN_W * int'(rate_eff));
  assign sh_s = SW'(SCREEN_H * int'(rate_eff));

  // latched command
  logic                 kind_q;
  logic signed [VW-1:0] vx [3];
  logic signed [VW-1:0] vy [3];
  logic [CW-1:0]        col;
  logic [7:0]           rd_x, rd_y;
  logic signed [BW-1:0] blox, bhix, bloy, bhiy;
  logic signed [VW-1:0] mnx, mxx, mny, mxy;
  logic signed [VW:0]   mxx_c, mxy_c;

  assign mnx   = min3(vx0, vx1, vx2);
  assign mxx   = max3(vx0, vx1, vx2);
  assign mny   = min3(vy0, vy1, vy2);
  assign mxy   = max3(vy0, vy1, vy2);
  assign mxx_c = (VW+1)'(mxx) + (VW+1)'(15);
  assign mxy_c = (VW+1)'(mxy) + (VW+1)'(15);

  // setup registers
  logic signed [PW-1:0] cr1, cr_diff;
  logic signed [XW-1:0] xs [3];
  logic signed [XW-1:0] ys [3];
  logic signed [SW-1:0] lox, hix, loy, hiy, sx, sy;
  logic [AW-1:0]        row_base, rd_base;
  logic signed [EW-1:0] erow [3];
  logic signed [EW-1:0] ecur [3];
  logic signed [EW-1:0] stepx [3];
  logic signed [EW-1:0] stepy [3];
  logic signed [OPW-1:0] px0, py0;

  // shared multiplier
  logic signed [OPW-1:0] opa, opb;
  logic signed [PW-1:0]  prod, prod_q;
  op_t                   op_q;
  logic [RW:0]           srate2;

  assign srate2 = {rate_eff, 1'b0};
  assign px0    = (OPW'(lox) <<< 5) + OPW'(16);
  assign py0    = (OPW'(loy) <<< 5) + OPW'(16);

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      OP_CR1: begin
        opa = OPW'(vx[1]) - OPW'(vx[0]);
        opb = OPW'(vy[2]) - OPW'(vy[0]);
      end
      OP_CR2: begin
        opa = OPW'(vy[1]) - OPW'(vy[0]);
        opb = OPW'(vx[2]) - OPW'(vx[0]);
      end
      OP_SX0: begin opa = OPW'(vx[0]); opb = OPW'($signed({1'b0, srate2})); end
      OP_SY0: begin opa = OPW'(vy[0]); opb = OPW'($signed({1'b0, srate2})); end
      OP_SX1: begin opa = OPW'(vx[1]); opb = OPW'($signed({1'b0, srate2})); end
      OP_SY1: begin opa = OPW'(vy[1]); opb = OPW'($signed({1'b0, srate2})); end
      OP_SX2: begin opa = OPW'(vx[2]); opb = OPW'($signed({1'b0, srate2})); end
      OP_SY2: begin opa = OPW'(vy[2]); opb = OPW'($signed({1'b0, srate2})); end
      OP_LOX: begin opa = OPW'(blox); opb = OPW'($signed({1'b0, rate_eff})); end
      OP_HIX: begin opa = OPW'(bhix); opb = OPW'($signed({1'b0, rate_eff})); end
      OP_LOY: begin opa = OPW'(bloy); opb = OPW'($signed({1'b0, rate_eff})); end
      OP_HIY: begin opa = OPW'(bhiy); opb = OPW'($signed({1'b0, rate_eff})); end
      OP_RB:  begin opa = OPW'(loy);  opb = OPW'(sw_s); end
      OP_E0A: begin
        opa = px0 - OPW'(xs[0]);
        opb = OPW'(ys[1]) - OPW'(ys[0]);
      end
      OP_E0B: begin
        opa = py0 - OPW'(ys[0]);
        opb = OPW'(xs[1]) - OPW'(xs[0]);
      end
      OP_E1A: begin
        opa = px0 - OPW'(xs[1]);
        opb = OPW'(ys[2]) - OPW'(ys[1]);
      end
      OP_E1B: begin
        opa = py0 - OPW'(ys[1]);
        opb = OPW'(xs[2]) - OPW'(xs[1]);
      end
      OP_E2A: begin
        opa = px0 - OPW'(xs[2]);
        opb = OPW'(ys[0]) - OPW'(ys[2]);
      end
      OP_E2B: begin
        opa = py0 - OPW'(ys[2]);
        opb = OPW'(xs[0]) - OPW'(xs[2]);
      end
      OP_RDB: begin
        opa = OPW'($signed({1'b0, rd_y}));
        opb = OPW'(sw_s);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod    = opa * opb;
  assign cr_diff = cr1 - prod_q;

  always_ff @(posedge clk) begin
    if (rst) op_q <= OP_NONE;
    else op_q <= cmd.op;
    prod_q <= prod;
  end

  // edge increments per sample step (32 units of 1/(32*rate) pixel)
  assign stepx[0] = (EW'(ys[1]) - EW'(ys[0])) <<< 5;
  assign stepx[1] = (EW'(ys[2]) - EW'(ys[1])) <<< 5;
  assign stepx[2] = (EW'(ys[0]) - EW'(ys[2])) <<< 5;
  assign stepy[0] = (EW'(xs[1]) - EW'(xs[0])) <<< 5;
  assign stepy[1] = (EW'(xs[2]) - EW'(xs[1])) <<< 5;
  assign stepy[2] = (EW'(xs[0]) - EW'(xs[2])) <<< 5;

  // scan
  logic          covered, sx_end, sy_end;
  logic [AW-1:0] scan_addr, rd_addr;
  logic          rd_in;
  logic [CNTW-1:0] count;

  assign covered   = cmd.scan_en && ecur[0][EW-1] && ecur[1][EW-1] && ecur[2][EW-1];
  assign sx_end    = (sx + SW'(1)) >= hix;
  assign sy_end    = (sy + SW'(1)) >= hiy;
  assign scan_addr = row_base + AW'($unsigned(sx));
  assign rd_addr   = rd_base + AW'(rd_x);
  assign rd_in     = ($signed(SW'(rd_x)) < sw_s) && ($signed(SW'(rd_y)) < sh_s);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_cmd;
      vx[0]  <= vx0;
      vy[0]  <= vy0;
      vx[1]  <= vx1;
      vy[1]  <= vy1;
      vx[2]  <= vx2;
      vy[2]  <= vy2;
      col    <= color_rgba;
      rd_x   <= read_sx;
      rd_y   <= read_sy;
      blox   <= BW'(mnx >>> 4);
      bloy   <= BW'(mny >>> 4);
      bhix   <= BW'(mxx_c >>> 4);
      bhiy   <= BW'(mxy_c >>> 4);
      count  <= '0;
    end else begin
      case (op_q)
        OP_CR1: cr1 <= prod_q;
        OP_CR2: begin
          if (cr_diff[PW-1]) begin
            vx[1] <= vx[2];
            vx[2] <= vx[1];
            vy[1] <= vy[2];
            vy[2] <= vy[1];
          end
        end
        OP_SX0: xs[0] <= XW'(prod_q);
        OP_SY0: ys[0] <= XW'(prod_q);
        OP_SX1: xs[1] <= XW'(prod_q);
        OP_SY1: ys[1] <= XW'(prod_q);
        OP_SX2: xs[2] <= XW'(prod_q);
        OP_SY2: ys[2] <= XW'(prod_q);
        OP_LOX: lox <= prod_q[PW-1] ? '0 : SW'(prod_q);
        OP_HIX: hix <= (prod_q > PW'(sw_s)) ? sw_s : SW'(prod_q);
        OP_LOY: loy <= prod_q[PW-1] ? '0 : SW'(prod_q);
        OP_HIY: hiy <= (prod_q > PW'(sh_s)) ? sh_s : SW'(prod_q);
        OP_RB:  row_base <= AW'(prod_q);
        OP_E0A: erow[0] <= EW'(prod_q);
        OP_E0B: erow[0] <= erow[0] - EW'(prod_q);
        OP_E1A: erow[1] <= EW'(prod_q);
        OP_E1B: erow[1] <= erow[1] - EW'(prod_q);
        OP_E2A: erow[2] <= EW'(prod_q);
        OP_E2B: erow[2] <= erow[2] - EW'(prod_q);
        OP_RDB: rd_base <= AW'(prod_q);
        default: ;
      endcase
      if (cmd.scan_init) begin
        sx <= lox;
        sy <= loy;
        for (int e = 0; e < 3; e++) ecur[e] <= erow[e];
      end else if (cmd.scan_en) begin
        count <= count + CNTW'(covered);
        if (!sx_end) begin
          sx <= sx + SW'(1);
          for (int e = 0; e < 3; e++) ecur[e] <= ecur[e] + stepx[e];
        end else begin
          sx       <= lox;
          sy       <= sy + SW'(1);
          row_base <= row_base + AW'($unsigned(sw_s));
          for (int e = 0; e < 3; e++) begin
            erow[e] <= erow[e] - stepy[e];
            ecur[e] <= erow[e] - stepy[e];
          end
        end
      end
    end
  end

  // sample store and clear pass
  logic [AW-1:0] clr_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata, blend_word;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_en) clr_addr <= clr_addr + AW'(1);
  end

  // blend pipeline: read, products, numerators, reciprocal estimates, correction and write
  logic          v1, v2, v3, v4;
  logic [AW-1:0] a1, a2, a3, a4;
  logic [7:0]    ea, inv_ea, ca;
  logic [15:0]   ta2, t12;
  logic [15:0]   ec2 [3];
  logic [7:0]    cc2 [3];
  logic [23:0]   n3 [3];
  logic [15:0]   na3;
  logic [23:0]   n4 [3];
  logic [15:0]   na4;
  logic [7:0]    qc4 [3];
  logic [7:0]    qa4;
  logic [32:0]   qm [3];
  logic [24:0]   qam;
  logic [24:0]   rc [3];
  logic [15:0]   ra;
  logic [7:0]    qc [3];
  logic [7:0]    qa;

  assign ea     = col[31:24];
  assign inv_ea = 8'd255 - ea;
  assign ca     = ram_rdata[31:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= covered;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    a1  <= scan_addr;
    a2  <= a1;
    a3  <= a2;
    a4  <= a3;
    ta2 <= 16'(inv_ea * (8'd255 - ca));
    t12 <= 16'(inv_ea * ca);
    for (int k = 0; k < 3; k++) begin
      ec2[k] <= 16'(ea * col[8*k +: 8]);
      cc2[k] <= ram_rdata[8*k +: 8];
      n3[k]  <= 24'(t12 * cc2[k]) + ({8'd0, ec2[k]} << 8) - {8'd0, ec2[k]};
      n4[k]  <= n3[k];
      qc4[k] <= qm[k][31:24];
    end
    na3 <= 16'd65025 - ta2;
    na4 <= na3;
    qa4 <= qam[23:16];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qm[k] = 33'(n3[k]) * 33'd258;
      rc[k] = 25'(n4[k]) - 25'(qc4[k]) * 25'd65025;
      qc[k] = (rc[k] >= 25'd65025) ? qc4[k] + 8'd1 : qc4[k];
    end
    qam = 25'(na3) * 25'd257;
    ra  = na4 - 16'(qa4) * 16'd255;
    qa  = (ra >= 16'd255) ? qa4 + 8'd1 : qa4;
  end

  assign blend_word = {qa, qc[2], qc[1], qc[0]};
  assign ram_we     = cmd.clear_en | v4;
  assign ram_waddr  = cmd.clear_en ? clr_addr : a4;
  assign ram_wdata  = cmd.clear_en ? '0 : blend_word;
  assign ram_raddr  = cmd.rd_req ? rd_addr : scan_addr;

  str_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read capture and result register
  logic [CW-1:0] rd_word;
  logic          rd_in_q;

  always_ff @(posedge clk) begin
    if (cmd.rd_req) rd_in_q <= rd_in;
    if (cmd.rd_capture) rd_word <= rd_in_q ? ram_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      result_kind   <= (kind_q == CMD_READ) ? KIND_READ : KIND_DONE;
      sample_rgba   <= (kind_q == CMD_READ) ? rd_word : '0;
      covered_count <= (kind_q == CMD_READ) ? '0 : count;
    end
  end

  assign status.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign status.bbox_empty = !((lox < hix) && (loy < hiy));
  assign status.scan_last  = sx_end && sy_end;
  assign status.pipe_busy  = v1 | v2 | v3 | v4;
  assign status.out_free   = !out_valid || out_ready;

endmodule

### design/supersampled_triangle_rasterizer.sv
// Top level: configuration port, controller and datapath of the supersampled rasteriser.
// Read transaction: row base multiply, its store, store read request, capture, result load. Draw:
// setup sequence, scan start, scan of the clipped bounding box, pipeline drain, result load.
// One command is in flight at a time; the next is taken when the controller is back in
// idle, while the previous result may still wait in the output register.
// After reset a clearing pass writes zero to all SCREEN_W*MAX_RATE*SCREEN_H*MAX_RATE store
// words, one per cycle (65536 words at default sizes); no command is taken meanwhile.
module supersampled_triangle_rasterizer #(
  parameter int SCREEN_W = 64,
  parameter int SCREEN_H = 64,
  parameter int MAX_RATE = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [str_pkg::VW-1:0] vx0,
  input  logic signed [str_pkg::VW-1:0] vy0,
  input  logic signed [str_pkg::VW-1:0] vx1,
  input  logic signed [str_pkg::VW-1:0] vy1,
  input  logic signed [str_pkg::VW-1:0] vx2,
  input  logic signed [str_pkg::VW-1:0] vy2,
  input  logic [str_pkg::CW-1:0]        color_rgba,
  input  logic [7:0]                    read_sx,
  input  logic [7:0]                    read_sy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [str_pkg::CW-1:0]        sample_rgba,
  output logic [str_pkg::CNTW-1:0]      covered_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import str_pkg::*;

  logic [2:0] rate_cfg;
  ctrl_cmd_t  ctl;
  dp_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_cfg <= 3'd1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RATE)) begin
      rate_cfg <= pwdata[2:0];
    end
  end

  assign prdata = (paddr[2] == REG_RATE) ? {29'd0, rate_cfg} : 32'd0;

  str_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (ctl)
  );

  str_dp #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .MAX_RATE (MAX_RATE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctl),
    .status        (status),
    .rate_cfg      (rate_cfg),
    .in_cmd        (cmd),
    .vx0           (vx0),
    .vy0           (vy0),
    .vx1           (vx1),
    .vy1           (vy1),
    .vx2           (vx2),
    .vy2           (vy2),
    .color_rgba    (color_rgba),
    .read_sx       (read_sx),
    .read_sy       (read_sy),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .result_kind   (result_kind),
    .sample_rgba   (sample_rgba),
    .covered_count (covered_count)
  );

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_en |-> !in_ready)
    else $error("transaction offered while store clearing");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> in_valid && in_ready)
    else $error("command latched without a transaction");
  a_drained: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !status.pipe_busy)
    else $error("result issued with blends in flight");
  a_out_set: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> out_valid)
    else $error("result register not loaded");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.clear_en, ctl.scan_en, ctl.scan_init, ctl.out_load}))
    else $error("conflicting controller commands");
`endif

endmodule

### sim/tb_supersampled_triangle_rasterizer.sv
// Self-checking testbench of the supersampled triangle rasteriser: draws and sample reads.
module tb_supersampled_triangle_rasterizer;
  import str_pkg::*;

  localparam int SCR_W = 64;
  localparam int SCR_H = 64;
  localparam int RATE_MAX = 4;
  localparam int CYCLE_LIMIT = 12000000;

  typedef struct {
    logic                 cmd;
    logic signed [VW-1:0] x0, y0, x1, y1, x2, y2;
    logic [CW-1:0]        colour;
    logic [7:0]           rx, ry;
  } raster_cmd_t;

  typedef struct {
    logic            kind;
    logic [CW-1:0]   word;
    logic [CNTW-1:0] count;
  } raster_res_t;

  class raster_scoreboard;
    bit [31:0]   samples [0:65535];
    bit [2:0]    rate_reg;
    raster_res_t expected_results[$];
    int          errors;
    int          draws, reads, covered_total;

    function new();
      rate_reg = 3'd1;
      errors = 0;
    endfunction

    function int eff_rate();
      int r;
      r = rate_reg;
      if (r == 0) r = 1;
      if (r > RATE_MAX) r = RATE_MAX;
      return r;
    endfunction

    function bit [31:0] blend(bit [31:0] col, bit [31:0] dst);
      int unsigned ea, ca, ec, cc, v;
      bit [31:0] res;
      ea = col[31:24];
      ca = dst[31:24];
      res = 0;
      res[31:24] = 8'((255 * 255 - (255 - ea) * (255 - ca)) / 255);
      for (int k = 0; k < 3; k++) begin
        ec = (col >> (8 * k)) & 8'hff;
        cc = (dst >> (8 * k)) & 8'hff;
        v = ((255 - ea) * cc * ca + ea * ec * 255) / (255 * 255);
        res = res | ((v & 8'hff) << (8 * k));
      end
      return res;
    endfunction

    function longint edge_fn(longint px, longint py, longint xa, longint ya,
                             longint xb, longint yb);
      return (px - xa) * (yb - ya) - (py - ya) * (xb - xa);
    endfunction

    function int pfloor(int v);
      return (v + 65536) / 16 - 4096;
    endfunction

    function int pceil(int v);
      return (v + 65536 + 15) / 16 - 4096;
    endfunction

    function void note_command(raster_cmd_t c);
      int r, sw, sh, lox, hix, loy, hiy, x0, y0, x1, y1, x2, y2, t, idx;
      longint cr, s, px, py;
      raster_res_t e;
      r = eff_rate();
      sw = SCR_W * r;
      sh = SCR_H * r;
      e.kind = KIND_READ;
      e.word = 0;
      e.count = 0;
      if (c.cmd == CMD_READ) begin
        reads++;
        if (c.rx < sw && c.ry < sh) e.word = samples[c.ry * sw + c.rx];
      end else begin
        draws++;
        e.kind = KIND_DONE;
        x0 = c.x0; y0 = c.y0; x1 = c.x1; y1 = c.y1; x2 = c.x2; y2 = c.y2;
        cr = longint'(x1 - x0) * (y2 - y0) - longint'(y1 - y0) * (x2 - x0);
        if (cr < 0) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
        end
        s = 2 * r;
        lox = pfloor(min3(VW'(x0), VW'(x1), VW'(x2))) * r;
        hix = pceil(max3(VW'(x0), VW'(x1), VW'(x2))) * r;
        loy = pfloor(min3(VW'(y0), VW'(y1), VW'(y2))) * r;
        hiy = pceil(max3(VW'(y0), VW'(y1), VW'(y2))) * r;
        if (lox < 0) lox = 0;
        if (loy < 0) loy = 0;
        if (hix > sw) hix = sw;
        if (hiy > sh) hiy = sh;
        for (int sy = loy; sy < hiy; sy++) begin
          py = (2 * sy + 1) * 16;
          for (int sx = lox; sx < hix; sx++) begin
            px = (2 * sx + 1) * 16;
            if (edge_fn(px, py, x0 * s, y0 * s, x1 * s, y1 * s) < 0 &&
                edge_fn(px, py, x1 * s, y1 * s, x2 * s, y2 * s) < 0 &&
                edge_fn(px, py, x2 * s, y2 * s, x0 * s, y0 * s) < 0) begin
              idx = sy * sw + sx;
              samples[idx] = blend(c.colour, samples[idx]);
              e.count++;
            end
          end
        end
        covered_total += e.count;
      end
      expected_results.push_back(e);
    endfunction

    function void check_result(logic kind, logic [CW-1:0] word, logic [CNTW-1:0] count);
      raster_res_t e;
      if (expected_results.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (kind !== e.kind) begin
        $error("result_kind expected %0d actual %0d", e.kind, kind);
        errors++;
      end
      if (word !== e.word) begin
        $error("sample_rgba expected %08h actual %08h", e.word, word);
        errors++;
      end
      if (count !== e.count) begin
        $error("covered_count expected %0d actual %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready, cmd = 0;
  logic signed [VW-1:0] vx0 = 0, vy0 = 0, vx1 = 0, vy1 = 0, vx2 = 0, vy2 = 0;
  logic [CW-1:0] color_rgba = 0;
  logic [7:0] read_sx = 0, read_sy = 0;
  logic out_valid, out_ready = 0, result_kind;
  logic [CW-1:0] sample_rgba;
  logic [CNTW-1:0] covered_count;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  raster_scoreboard sb = new();
  int cycles = 0;
  bit calm = 0;

  supersampled_triangle_rasterizer uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_result(result_kind, sample_rgba, covered_count);
    end
  end

  task automatic send_cmd(raster_cmd_t c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c.cmd;
    vx0 <= c.x0; vy0 <= c.y0; vx1 <= c.x1; vy1 <= c.y1; vx2 <= c.x2; vy2 <= c.y2;
    color_rgba <= c.colour;
    read_sx <= c.rx;
    read_sy <= c.ry;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_command(c);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_rate(bit [2:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 3'(REG_RATE) << 2;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.rate_reg = v;
  endtask

  function automatic raster_cmd_t tri_cmd(int x0, int y0, int x1, int y1, int x2, int y2,
                                          bit [31:0] col);
    raster_cmd_t c;
    c.cmd = CMD_DRAW;
    c.x0 = VW'(x0); c.y0 = VW'(y0); c.x1 = VW'(x1);
    c.y1 = VW'(y1); c.x2 = VW'(x2); c.y2 = VW'(y2);
    c.colour = col;
    c.rx = 8'($urandom); c.ry = 8'($urandom);
    return c;
  endfunction

  function automatic raster_cmd_t read_cmd(int rx, int ry);
    raster_cmd_t c;
    c = tri_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    c.cmd = CMD_READ;
    c.rx = 8'(rx); c.ry = 8'(ry);
    return c;
  endfunction

  function automatic int clampv(int v);
    if (v < -4096) return -4096;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic raster_cmd_t rand_cmd(int r);
    int cx, cy, sp;
    bit [31:0] col;
    raster_cmd_t c;
    col = $urandom;
    if ($urandom_range(0, 3) == 0) col[31:24] = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1)) return read_cmd($urandom_range(0, 255), $urandom_range(0, 255));
      return read_cmd($urandom_range(0, 8 * r), $urandom_range(0, 8 * r));
    end
    if ($urandom_range(0, 60) == 0)
      return tri_cmd($urandom, $urandom, $urandom_range(0, 2000), $urandom_range(0, 2000),
                     $urandom, $urandom, col);
    sp = $urandom_range(1, 64);
    cx = $urandom_range(0, 140) - 12;
    cy = $urandom_range(0, 140) - 12;
    if ($urandom_range(0, 2) != 0) begin
      cx = $urandom_range(0, 40) - 8;
      cy = $urandom_range(0, 40) - 8;
    end
    if ($urandom_range(0, 5) == 0) cx = cx * 8;
    if ($urandom_range(0, 5) == 0) cy = cy * 8;
    c = tri_cmd(clampv(cx + $urandom_range(0, 2 * sp) - sp), clampv(cy + $urandom_range(0, 2 * sp) - sp),
                clampv(cx + $urandom_range(0, 2 * sp) - sp), clampv(cy + $urandom_range(0, 2 * sp) - sp),
                clampv(cx + $urandom_range(0, 2 * sp) - sp), clampv(cy + $urandom_range(0, 2 * sp) - sp),
                col);
    if ($urandom_range(0, 30) == 0) begin
      c.x2 = VW'(c.x0 + 2 * (c.x1 - c.x0));
      c.y2 = VW'(c.y0 + 2 * (c.y1 - c.y0));
    end
    return c;
  endfunction

  initial begin : stimulus
    int rates[7] = '{1, 4, 0, 2, 7, 3, 5};
    int n;
    repeat (5) @(posedge clk);
    rst <= 0;
    do @(posedge clk); while (!in_ready);
    write_rate(3'd4);
    calm = 1;
    send_cmd(tri_cmd(-4096, -4096, 4095, -4096, -4096, 4095, 32'h80ff4020));
    send_cmd(tri_cmd(4095, 4095, 4095, -4096, -4096, 4095, 32'hff102030));
    calm = 0;
    send_cmd(tri_cmd(16, 16, 80, 16, 16, 80, 32'h00ffffff));
    send_cmd(tri_cmd(16, 16, 16, 80, 80, 16, 32'hffffffff));
    send_cmd(tri_cmd(0, 0, 0, 0, 0, 0, 32'hffffffff));
    send_cmd(tri_cmd(0, 0, 32, 32, 64, 64, 32'hffffffff));
    send_cmd(tri_cmd(-4096, 0, 4095, 0, 100, 4095, 32'h00000000));
    send_cmd(tri_cmd(1000, 900, 1100, 1000, 900, 1010, 32'h7f00ff00));
    send_cmd(read_cmd(2, 2));
    send_cmd(read_cmd(255, 255));
    send_cmd(read_cmd(0, 0));
    send_cmd(read_cmd(128, 200));
    drain();
    write_rate(3'd1);
    send_cmd(read_cmd(64, 3));
    send_cmd(read_cmd(3, 64));
    send_cmd(read_cmd(63, 63));
    send_cmd(tri_cmd(-40, -40, 1100, -20, 20, 1100, 32'hc0336699));
    send_cmd(read_cmd(5, 5));
    drain();
    foreach (rates[i]) begin
      write_rate(3'(rates[i]));
      n = (rates[i] == 7 || rates[i] == 0) ? 110 : 190;
      for (int k = 0; k < n; k++) begin
        if (k % 60 == 0) calm = ($urandom_range(0, 3) == 0);
        if (k == n / 2) begin
          in_valid <= 0;
          while (sb.expected_results.size() != 0) @(posedge clk);
        end
        send_cmd(rand_cmd(sb.eff_rate()));
      end
      drain();
    end
    calm = 0;
    if (sb.expected_results.size() != 0) begin
      $error("%0d results never arrived", sb.expected_results.size());
      sb.errors++;
    end
    $display("Ran %0d draws and %0d reads over seven rate settings, out-of-range ones too.",
             sb.draws, sb.reads);
    $display("Draws covered %0d samples in total.", sb.covered_total);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
